/* design/segment_to_segment_distance_unit_macros.svh */
// ----------------------------------------------------------------------------
// segment distance unit assertion macros
// shared concurrent assertion forms for the segment distance checker
// ----------------------------------------------------------------------------
`ifndef SEGMENT_TO_SEGMENT_DISTANCE_UNIT_MACROS_SVH
`define SEGMENT_TO_SEGMENT_DISTANCE_UNIT_MACROS_SVH

// antecedent in the same cycle implies consequent
`define S2SD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// a stalled request stays valid and keeps its payload
`define S2SD_ASSERT_HOLD(lbl, clk, rstn, vld, stl, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && (stl)) |=> ((vld) && $stable(sig))) else $error(msg);

`endif

/* design/s2sd_pkg.sv */
// ----------------------------------------------------------------------------
// s2sd_pkg
// types, widths and arithmetic helpers of the segment distance unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package s2sd_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIST_BITS     = 33;
  localparam int DIFF_BITS     = COORD_BITS + 1;
  // signed cross and dot products
  localparam int PROD_BITS     = 2 * COORD_BITS + 4;
  // squared lengths and cross magnitudes
  localparam int SQ_BITS       = 2 * COORD_BITS + 3;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg1_x0;
    logic signed [COORD_BITS-1:0] seg1_y0;
    logic signed [COORD_BITS-1:0] seg1_x1;
    logic signed [COORD_BITS-1:0] seg1_y1;
    logic signed [COORD_BITS-1:0] seg2_x0;
    logic signed [COORD_BITS-1:0] seg2_y0;
    logic signed [COORD_BITS-1:0] seg2_x1;
    logic signed [COORD_BITS-1:0] seg2_y1;
  } s2sd_in_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] distance_fixed;
    logic                 segments_touch;
  } s2sd_out_t;

  typedef struct packed {
    logic valid;
    logic touch;
  } s2sd_ctl_t;

  function automatic logic signed [DIFF_BITS-1:0] diff(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] q
  );
    return DIFF_BITS'(p) - DIFF_BITS'(q);
  endfunction

  function automatic logic signed [PROD_BITS-1:0] cross2(
    input logic signed [DIFF_BITS-1:0] ux,
    input logic signed [DIFF_BITS-1:0] uy,
    input logic signed [DIFF_BITS-1:0] vx,
    input logic signed [DIFF_BITS-1:0] vy
  );
    return PROD_BITS'(ux) * PROD_BITS'(vy) - PROD_BITS'(uy) * PROD_BITS'(vx);
  endfunction

  function automatic logic signed [PROD_BITS-1:0] dot2(
    input logic signed [DIFF_BITS-1:0] ux,
    input logic signed [DIFF_BITS-1:0] uy,
    input logic signed [DIFF_BITS-1:0] vx,
    input logic signed [DIFF_BITS-1:0] vy
  );
    return PROD_BITS'(ux) * PROD_BITS'(vx) + PROD_BITS'(uy) * PROD_BITS'(vy);
  endfunction

  function automatic logic [SQ_BITS-1:0] sqsum(
    input logic signed [DIFF_BITS-1:0] dx,
    input logic signed [DIFF_BITS-1:0] dy
  );
    logic signed [PROD_BITS-1:0] s;
    s = dot2(dx, dy, dx, dy);
    return s[SQ_BITS-1:0];
  endfunction

  function automatic logic [SQ_BITS-1:0] mag(input logic signed [PROD_BITS-1:0] v);
    logic signed [PROD_BITS-1:0] n;
    n = -v;
    return v[PROD_BITS-1] ? n[SQ_BITS-1:0] : v[SQ_BITS-1:0];
  endfunction

  function automatic logic in_span(
    input logic signed [COORD_BITS-1:0] p,
    input logic signed [COORD_BITS-1:0] e0,
    input logic signed [COORD_BITS-1:0] e1
  );
    return (p >= e0 && p <= e1) || (p >= e1 && p <= e0);
  endfunction

endpackage

`default_nettype wire

/* design/s2sd_div.sv */
// ----------------------------------------------------------------------------
// s2sd_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s2sd_div #(
  parameter int DVW = 35,
  parameter int QW  = 67,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [DVW-1:0] top_i,
  input  logic [QW-1:0]  low_i,
  input  logic [DVW-1:0] div_i,
  input  logic [SBW-1:0] side_i,
  output logic [QW-1:0]  quo_o,
  output logic [SBW-1:0] side_o
);

  logic [DVW-1:0] rem_q  [QW-1];
  logic [DVW-1:0] div_q  [QW-1];
  logic [QW-1:0]  low_q  [QW];
  logic [SBW-1:0] side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DVW-1:0] rem_in;
    logic [DVW-1:0] div_in;
    logic [QW-1:0]  low_in;
    logic [SBW-1:0] side_in;
    logic [DVW:0]   sh;
    logic [DVW:0]   sub;
    logic           ge;
    logic [DVW-1:0] rem_d;
    logic [QW-1:0]  low_d;

    if (k == 0) begin : g_first
      assign rem_in  = top_i;
      assign div_in  = div_i;
      assign low_in  = low_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign div_in  = div_q[k-1];
      assign low_in  = low_q[k-1];
      assign side_in = side_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign sh    = {rem_in, low_in[QW-1]};
    assign sub   = sh - {1'b0, div_in};
    assign ge    = sh >= {1'b0, div_in};
    assign rem_d = ge ? sub[DVW-1:0] : sh[DVW-1:0];
    assign low_d = {low_in[QW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        low_q[k] <= low_d;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          div_q[k] <= div_in;
        end
      end
    end
  end

  assign quo_o  = low_q[QW-1];
  assign side_o = side_q[QW-1];

endmodule

`default_nettype wire

/* design/s2sd_isqrt.sv */
// ----------------------------------------------------------------------------
// s2sd_isqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module s2sd_isqrt #(
  parameter int RW = 34
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [2*RW-1:0]      rad_i,
  input  s2sd_pkg::s2sd_ctl_t  ctl_i,
  output logic [RW-1:0]        root_o,
  output s2sd_pkg::s2sd_ctl_t  ctl_o
);

  import s2sd_pkg::*;

  logic [RW+2:0]   rem_q  [RW-1];
  logic [2*RW-1:0] rad_q  [RW-1];
  logic [RW-1:0]   root_q [RW];
  s2sd_ctl_t       ctl_q  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW+2:0]   rem_in;
    logic [2*RW-1:0] rad_in;
    logic [RW-1:0]   root_in;
    s2sd_ctl_t       ctl_in;
    logic [RW+2:0]   sh;
    logic [RW+2:0]   trial;
    logic            ge;
    logic [RW+2:0]   rem_d;
    logic [RW-1:0]   root_d;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rad_in  = rad_i;
      assign root_in = '0;
      assign ctl_in  = ctl_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign root_in = root_q[k-1];
      assign ctl_in  = ctl_q[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign sh     = {rem_in[RW:0], rad_in[2*RW-1:2*RW-2]};
    assign trial  = (RW+3)'({root_in, 2'b01});
    assign ge     = sh >= trial;
    assign rem_d  = ge ? sh - trial : sh;
    assign root_d = {root_in[RW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_d;
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_d;
          rad_q[k] <= rad_in << 2;
        end
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign ctl_o  = ctl_q[RW-1];

endmodule

`default_nettype wire

/* design/segment_to_segment_distance_unit.sv */
// path: request register, stages 1 to 3, divider chains, stage 4, square root chain;
//   QW = 2*COORD_BITS + 3 + 2*FRAC_BITS quotient bits, RW = ceil(QW/2) root bits
// throughput: one request per cycle while the output is not stalled; the whole pipeline
//   advances together and is held as a whole while the output register is stalled
// reset: asynchronous, active low, clears valid and side bits; other payload registers keep no reset
// ----------------------------------------------------------------------------
// segment_to_segment_distance_unit
// minimum distance between two 2-d segments, unsigned fixed point, truncated
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module segment_to_segment_distance_unit #(
  parameter int FRAC_BITS = s2sd_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  s2sd_pkg::s2sd_in_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output s2sd_pkg::s2sd_out_t out_req_o
);

  import s2sd_pkg::*;

  // squared distance in fixed point needs QW bits, its root RW bits
  localparam int LW = SQ_BITS;
  localparam int QW = LW + 2 * FRAC_BITS;
  localparam int RW = (QW + 1) / 2;
  localparam int SB = LW + 3;

  // whole pipeline moves when the output register is free or being drained
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // stage 0: capture the request
  // --------------------------------------------------------------------------
  s2sd_in_t in_q;
  logic     v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_req_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: edge vectors, cross products, projection tests, squared lengths
  // a, b are the first segment, c, d the second
  // --------------------------------------------------------------------------
  logic signed [DIFF_BITS-1:0] dc_x, dc_y, cd_x, cd_y, ba_x, ba_y, ab_x, ab_y;
  logic signed [DIFF_BITS-1:0] ac_x, ac_y, ca_x, ca_y, ad_x, ad_y, da_x, da_y;
  logic signed [DIFF_BITS-1:0] bc_x, bc_y, cb_x, cb_y, bd_x, bd_y, db_x, db_y;

  assign dc_x = diff(in_q.seg2_x1, in_q.seg2_x0);
  assign dc_y = diff(in_q.seg2_y1, in_q.seg2_y0);
  assign cd_x = diff(in_q.seg2_x0, in_q.seg2_x1);
  assign cd_y = diff(in_q.seg2_y0, in_q.seg2_y1);
  assign ba_x = diff(in_q.seg1_x1, in_q.seg1_x0);
  assign ba_y = diff(in_q.seg1_y1, in_q.seg1_y0);
  assign ab_x = diff(in_q.seg1_x0, in_q.seg1_x1);
  assign ab_y = diff(in_q.seg1_y0, in_q.seg1_y1);
  assign ac_x = diff(in_q.seg1_x0, in_q.seg2_x0);
  assign ac_y = diff(in_q.seg1_y0, in_q.seg2_y0);
  assign ca_x = diff(in_q.seg2_x0, in_q.seg1_x0);
  assign ca_y = diff(in_q.seg2_y0, in_q.seg1_y0);
  assign ad_x = diff(in_q.seg1_x0, in_q.seg2_x1);
  assign ad_y = diff(in_q.seg1_y0, in_q.seg2_y1);
  assign da_x = diff(in_q.seg2_x1, in_q.seg1_x0);
  assign da_y = diff(in_q.seg2_y1, in_q.seg1_y0);
  assign bc_x = diff(in_q.seg1_x1, in_q.seg2_x0);
  assign bc_y = diff(in_q.seg1_y1, in_q.seg2_y0);
  assign cb_x = diff(in_q.seg2_x0, in_q.seg1_x1);
  assign cb_y = diff(in_q.seg2_y0, in_q.seg1_y1);
  assign bd_x = diff(in_q.seg1_x1, in_q.seg2_x1);
  assign bd_y = diff(in_q.seg1_y1, in_q.seg2_y1);
  assign db_x = diff(in_q.seg2_x1, in_q.seg1_x1);
  assign db_y = diff(in_q.seg2_y1, in_q.seg1_y1);

  // an endpoint projects strictly inside the other segment when both dots are positive
  logic signed [PROD_BITS-1:0] dt_a1, dt_a2, dt_b1, dt_b2, dt_c1, dt_c2, dt_d1, dt_d2;
  assign dt_a1 = dot2(dc_x, dc_y, ac_x, ac_y);
  assign dt_a2 = dot2(cd_x, cd_y, ad_x, ad_y);
  assign dt_b1 = dot2(dc_x, dc_y, bc_x, bc_y);
  assign dt_b2 = dot2(cd_x, cd_y, bd_x, bd_y);
  assign dt_c1 = dot2(ba_x, ba_y, ca_x, ca_y);
  assign dt_c2 = dot2(ab_x, ab_y, cb_x, cb_y);
  assign dt_d1 = dot2(ba_x, ba_y, da_x, da_y);
  assign dt_d2 = dot2(ab_x, ab_y, db_x, db_y);

  logic signed [PROD_BITS-1:0] xa_q, xb_q, xc_q, xd_q;
  logic                        ina_q, inb_q, inc_q, ind_q;
  logic                        boxa_q, boxb_q, boxc_q, boxd_q;
  logic [LW-1:0]               lcd1_q, lab1_q, eac_q, ead_q, ebc_q, ebd_q;
  logic                        v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // orientation of each endpoint against the other segment's line
      xa_q   <= cross2(dc_x, dc_y, ac_x, ac_y);
      xb_q   <= cross2(dc_x, dc_y, bc_x, bc_y);
      xc_q   <= cross2(ba_x, ba_y, ca_x, ca_y);
      xd_q   <= cross2(ba_x, ba_y, da_x, da_y);
      ina_q  <= (dt_a1 > 0) && (dt_a2 > 0);
      inb_q  <= (dt_b1 > 0) && (dt_b2 > 0);
      inc_q  <= (dt_c1 > 0) && (dt_c2 > 0);
      ind_q  <= (dt_d1 > 0) && (dt_d2 > 0);
      boxa_q <= in_span(in_q.seg1_x0, in_q.seg2_x0, in_q.seg2_x1)
             && in_span(in_q.seg1_y0, in_q.seg2_y0, in_q.seg2_y1);
      boxb_q <= in_span(in_q.seg1_x1, in_q.seg2_x0, in_q.seg2_x1)
             && in_span(in_q.seg1_y1, in_q.seg2_y0, in_q.seg2_y1);
      boxc_q <= in_span(in_q.seg2_x0, in_q.seg1_x0, in_q.seg1_x1)
             && in_span(in_q.seg2_y0, in_q.seg1_y0, in_q.seg1_y1);
      boxd_q <= in_span(in_q.seg2_x1, in_q.seg1_x0, in_q.seg1_x1)
             && in_span(in_q.seg2_y1, in_q.seg1_y0, in_q.seg1_y1);
      lcd1_q <= sqsum(dc_x, dc_y);
      lab1_q <= sqsum(ba_x, ba_y);
      eac_q  <= sqsum(ac_x, ac_y);
      ead_q  <= sqsum(ad_x, ad_y);
      ebc_q  <= sqsum(bc_x, bc_y);
      ebd_q  <= sqsum(bd_x, bd_y);
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: contact test, nearest perpendicular per line, nearest endpoint pair
  // --------------------------------------------------------------------------
  logic pa, pb, pc, pd, na, nb, nc, nd, za, zb, zc, zd;
  logic proper, touch_d;
  logic [LW-1:0] mga, mgb, mgc, mgd, m1_d, m2_d, e01, e23, e_d;

  assign pa = !xa_q[PROD_BITS-1] && (xa_q != '0);
  assign pb = !xb_q[PROD_BITS-1] && (xb_q != '0);
  assign pc = !xc_q[PROD_BITS-1] && (xc_q != '0);
  assign pd = !xd_q[PROD_BITS-1] && (xd_q != '0);
  assign na = xa_q[PROD_BITS-1];
  assign nb = xb_q[PROD_BITS-1];
  assign nc = xc_q[PROD_BITS-1];
  assign nd = xd_q[PROD_BITS-1];
  assign za = (xa_q == '0);
  assign zb = (xb_q == '0);
  assign zc = (xc_q == '0);
  assign zd = (xd_q == '0);

  // proper crossing, or an endpoint lying on the other segment
  assign proper  = ((pa && nb) || (na && pb)) && ((pc && nd) || (nc && pd));
  assign touch_d = proper || (za && boxa_q) || (zb && boxb_q)
                || (zc && boxc_q) || (zd && boxd_q);

  assign mga = mag(xa_q);
  assign mgb = mag(xb_q);
  assign mgc = mag(xc_q);
  assign mgd = mag(xd_q);

  // same denominator per line, so the smaller cross magnitude wins
  always_comb begin
    m1_d = mga;
    if (!ina_q || (inb_q && mgb < mga)) begin
      m1_d = mgb;
    end
    m2_d = mgc;
    if (!inc_q || (ind_q && mgd < mgc)) begin
      m2_d = mgd;
    end
  end

  assign e01 = (eac_q < ead_q) ? eac_q : ead_q;
  assign e23 = (ebc_q < ebd_q) ? ebc_q : ebd_q;
  assign e_d = (e01 < e23) ? e01 : e23;

  logic [LW-1:0] m1_q, m2_q, lcd2_q, lab2_q, e2_q;
  logic          touch2_q, p1v2_q, p2v2_q, v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      lcd2_q   <= lcd1_q;
      lab2_q   <= lab1_q;
      e2_q     <= e_d;
      touch2_q <= touch_d;
      p1v2_q   <= ina_q || inb_q;
      p2v2_q   <= inc_q || ind_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: square the cross magnitudes
  // --------------------------------------------------------------------------
  logic [2*LW-1:0] n1_q, n2_q;
  logic [LW-1:0]   lcd3_q, lab3_q, e3_q;
  logic            touch3_q, p1v3_q, p2v3_q, v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q     <= m1_q * m1_q;
      n2_q     <= m2_q * m2_q;
      lcd3_q   <= lcd2_q;
      lab3_q   <= lab2_q;
      e3_q     <= e2_q;
      touch3_q <= touch2_q;
      p1v3_q   <= p1v2_q;
      p2v3_q   <= p2v2_q;
    end
  end

  // --------------------------------------------------------------------------
  // dividers: floor(cross^2 * 2^(2*FRAC_BITS) / len^2); the upper LW bits of the
  // scaled dividend are always below the divisor, so QW quotient bits suffice
  // --------------------------------------------------------------------------
  logic [LW-1:0] top1, top2, dv1, dv2;
  logic [QW-1:0] low1, low2, quo1, quo2;
  logic [SB-1:0] side1_i, side1_o;
  logic          side2_o;

  assign top1 = p1v3_q ? n1_q[2*LW-1:LW] : '0;
  assign top2 = p2v3_q ? n2_q[2*LW-1:LW] : '0;
  assign low1 = p1v3_q ? (QW'(n1_q[LW-1:0]) << (2 * FRAC_BITS)) : '0;
  assign low2 = p2v3_q ? (QW'(n2_q[LW-1:0]) << (2 * FRAC_BITS)) : '0;
  assign dv1  = p1v3_q ? lcd3_q : LW'(1);
  assign dv2  = p2v3_q ? lab3_q : LW'(1);

  assign side1_i = {v3_q, touch3_q, p1v3_q, e3_q};

  s2sd_div #(
    .DVW (LW),
    .QW  (QW),
    .SBW (SB)
  ) u_div_cd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .top_i  (top1),
    .low_i  (low1),
    .div_i  (dv1),
    .side_i (side1_i),
    .quo_o  (quo1),
    .side_o (side1_o)
  );

  s2sd_div #(
    .DVW (LW),
    .QW  (QW),
    .SBW (1)
  ) u_div_ab (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .top_i  (top2),
    .low_i  (low2),
    .div_i  (dv2),
    .side_i (p2v3_q),
    .quo_o  (quo2),
    .side_o (side2_o)
  );

  // --------------------------------------------------------------------------
  // stage 4: least squared distance in fixed point
  // --------------------------------------------------------------------------
  logic [LW-1:0] e4;
  logic          p1v4;
  logic [QW-1:0] qe, q1, q2, q12, qmin_d, qmin_q;
  s2sd_ctl_t     ctl4_d, ctl4_q;

  assign e4           = side1_o[LW-1:0];
  assign p1v4         = side1_o[LW];
  assign ctl4_d.touch = side1_o[LW+1];
  assign ctl4_d.valid = side1_o[LW+2];

  assign qe     = QW'(e4) << (2 * FRAC_BITS);
  assign q1     = p1v4 ? quo1 : '1;
  assign q2     = side2_o ? quo2 : '1;
  assign q12    = (q1 < q2) ? q1 : q2;
  assign qmin_d = (qe < q12) ? qe : q12;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else if (adv) begin
      ctl4_q <= ctl4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      qmin_q <= qmin_d;
    end
  end

  // --------------------------------------------------------------------------
  // square root; its last stage is the output register
  // --------------------------------------------------------------------------
  logic [RW-1:0]        root;
  s2sd_ctl_t            ctl_out;
  logic [DIST_BITS-1:0] dist_sat;

  s2sd_isqrt #(
    .RW (RW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .rad_i  ((2 * RW)'(qmin_q)),
    .ctl_i  (ctl4_q),
    .root_o (root),
    .ctl_o  (ctl_out)
  );

  // saturate when the root is wider than the result field
  if (RW > DIST_BITS) begin : g_sat
    assign dist_sat = (|root[RW-1:DIST_BITS]) ? '1 : root[DIST_BITS-1:0];
  end else begin : g_ext
    assign dist_sat = DIST_BITS'(root);
  end

  assign out_valid_o              = ctl_out.valid;
  assign out_req_o.segments_touch = ctl_out.touch;
  assign out_req_o.distance_fixed = ctl_out.touch ? '0 : dist_sat;

endmodule

`default_nettype wire

/* design/s2sd_chk.sv */
// ----------------------------------------------------------------------------
// s2sd_chk
// port level checks of the segment distance unit, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "segment_to_segment_distance_unit_macros.svh"

module s2sd_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input s2sd_pkg::s2sd_in_t  in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input s2sd_pkg::s2sd_out_t out_req_o
);

  import s2sd_pkg::*;

  // a held request keeps its payload
  `S2SD_ASSERT_HOLD(a_in_hold, clk_i, rst_ni, in_valid_i, in_stall_o, in_req_i,
                    "in held")

  // a held result keeps its payload
  `S2SD_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_req_o,
                    "out held")

  // contact always reports zero distance
  `S2SD_ASSERT_IMP(a_touch_zero, clk_i, rst_ni, out_valid_o && out_req_o.segments_touch,
                   out_req_o.distance_fixed == '0, "touch with distance")

  // input back pressure only comes from a blocked output
  `S2SD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i,
                   "stall without cause")

endmodule

bind segment_to_segment_distance_unit s2sd_chk u_chk (.*);

`default_nettype wire
